// File: hdl/frame_time_window_stats_macros.svh
// Assertion macros shared by the frame time window statistics modules.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef FRAME_TIME_WINDOW_STATS_MACROS_SVH
`define FRAME_TIME_WINDOW_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTWS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FTWS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ftws_pkg.sv
// Shared constants, types and helper functions of the frame time window statistics block.
// Depends on nothing; the other files that use it refer to it by scoped names.
package ftws_pkg;

	localparam int IN_W           = 16;
	localparam int SAMPLE_W       = 10;
	localparam int FPS_W          = 10;
	localparam int MS_PER_SEC     = 1000;
	localparam int WINDOW_DEPTH_DEF = 60;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(1);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(1000);

	// Divider operand selection codes.
	localparam int SEL_W = 2;
	localparam logic [SEL_W-1:0] SEL_AVG   = 2'd0;
	localparam logic [SEL_W-1:0] SEL_BEST  = 2'd1;
	localparam logic [SEL_W-1:0] SEL_WORST = 2'd2;
	localparam logic [SEL_W-1:0] SEL_INST  = 2'd3;

	typedef struct packed {
		logic             capture;
		logic             write;
		logic             clear_acc;
		logic             walk_step;
		logic             div_start;
		logic [SEL_W-1:0] div_sel;
		logic             load_out;
	} ftws_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic div_busy;
		logic div_done;
		logic out_free;
	} ftws_sts_t;

	// Clamp a raw frame time to the stored range of 1..1000 ms.
	function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [IN_W-1:0] raw);
		logic [SAMPLE_W-1:0] res;
		if (raw == '0) begin
			res = SAMPLE_MIN;
		end else if (raw > IN_W'(SAMPLE_MAX)) begin
			res = SAMPLE_MAX;
		end else begin
			res = raw[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: hdl/ftws_in_if.sv
// Input channel of the frame time window statistics block: one frame time per item.
// Depends on ftws_pkg for the field width.
interface ftws_in_if;
	logic                         valid;
	logic                         ready;
	logic [ftws_pkg::IN_W-1:0]    frame_millis;

	modport source (output valid, output frame_millis, input ready);
	modport sink (input valid, input frame_millis, output ready);
endinterface

// File: hdl/ftws_out_if.sv
// Result channel of the frame time window statistics block: four rate figures per item.
// Depends on ftws_pkg for the field widths.
interface ftws_out_if;
	logic                          valid;
	logic                          ready;
	logic [ftws_pkg::FPS_W-1:0]    avg_fps;
	logic [ftws_pkg::FPS_W-1:0]    best_excess;
	logic [ftws_pkg::FPS_W-1:0]    worst_deficit;
	logic [ftws_pkg::FPS_W-1:0]    instant_fps;

	modport source (output valid, output avg_fps, output best_excess,
		output worst_deficit, output instant_fps, input ready);
	modport sink (input valid, input avg_fps, input best_excess,
		input worst_deficit, input instant_fps, output ready);
endinterface

// File: hdl/frame_time_window_stats.sv
// Frame time window statistics, top level: joins controller and datapath.
// Depends on ftws_pkg, ftws_in_if, ftws_out_if, ftws_ctrl and ftws_dp.
//
// Usage. The samples channel takes one item per frame: the frame time in
// milliseconds, which is clamped to 1..1000 and stored in a ring of
// WINDOW_DEPTH entries. The results channel returns one item for every
// sample: the window average rate, the best-case excess and worst-case
// deficit against that average, and the instantaneous rate of the new sample.
// The time from accept to result valid is set by the walk over the ring, one
// memory read per cycle, and by four passes through the shared divider, one
// quotient bit per cycle. The divider width W is clog2(1000 * WINDOW_DEPTH + 1);
// with the default depth of 60 that is 16 bits. One item at a time: a new
// sample is accepted only when the controller is idle again, after the
// previous result has been loaded.
// A finished result waits in an output register, so the next sample is
// accepted and worked on while the receiver stalls; the block then holds
// only when that next result is ready and the register is still full.
// Reset clears the write position and every entry's valid bit, so the whole
// window reads as 1 ms per entry at once, with no clearing pass.
module frame_time_window_stats #(
	parameter int WINDOW_DEPTH = ftws_pkg::WINDOW_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ftws_in_if.sink     samples,
	ftws_out_if.source  results
);

	// Command and status bundles between the two halves.
	ftws_pkg::ftws_cmd_t cmd;
	ftws_pkg::ftws_sts_t sts;
	logic                in_ready;

	// The controller owns the input handshake; the datapath owns the result register.
	// samples.ready is high only between items, while the controller is idle.
	assign samples.ready = in_ready;

	ftws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftws_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_millis (samples.frame_millis),
		.cmd          (cmd),
		.sts          (sts),
		.results      (results)
	);

endmodule

// File: hdl/ftws_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its width parameter.
module ftws_div #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     dvd_q;
	logic [W-1:0]     dsr_q;
	logic [W-1:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       trial;
	logic             fits;

	// The dividend register shifts out its top bit and takes in the quotient bit.
	assign trial = {rem_q, dvd_q[W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], fits};
			if (fits) begin
				rem_q <= W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: hdl/ftws_dp.sv
// Datapath: sample ring memory, window walk accumulators, shared divider and result register.
// Depends on ftws_pkg, ftws_out_if, ftws_div and the assertion macro header.
`include "frame_time_window_stats_macros.svh"

module ftws_dp #(
	parameter int WINDOW_DEPTH = ftws_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ftws_pkg::IN_W-1:0]     frame_millis,
	input  ftws_pkg::ftws_cmd_t           cmd,
	output ftws_pkg::ftws_sts_t           sts,
	ftws_out_if.source                    results
);

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int TOT_W  = $clog2(ftws_pkg::MS_PER_SEC * WINDOW_DEPTH + 1);
	localparam int SW     = ftws_pkg::SAMPLE_W;
	localparam int FW     = ftws_pkg::FPS_W;

	logic [SW-1:0]           mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [ADDR_W-1:0]       wr_pos_q;
	logic [ADDR_W-1:0]       walk_q;
	logic                    walk_last;
	logic [SW-1:0]           sample_q;
	logic [SW-1:0]           rd_data_s1;
	logic                    rd_vld_s1;
	logic                    acc_en_s1;
	logic [SW-1:0]           entry;
	logic [TOT_W-1:0]        total_q;
	logic [SW-1:0]           min_q;
	logic [SW-1:0]           max_q;
	logic [TOT_W-1:0]        div_dvd;
	logic [TOT_W-1:0]        div_dsr;
	logic [TOT_W-1:0]        div_quot;
	logic                    div_busy;
	logic                    div_done;
	logic [FW-1:0]           avg_q;
	logic [FW-1:0]           best_q;
	logic [FW-1:0]           worst_q;
	logic [FW-1:0]           inst_q;
	logic                    out_valid_q;
	logic                    out_free;

	assign walk_last = walk_q == ADDR_W'(WINDOW_DEPTH - 1);

	// Entries never written since reset read as the reset value of one.
	assign entry = rd_vld_s1 ? rd_data_s1 : ftws_pkg::SAMPLE_MIN;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= ftws_pkg::clamp_sample(frame_millis);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_pos_q] <= sample_q;
		end
		if (cmd.walk_step) begin
			rd_data_s1 <= mem[walk_q];
			rd_vld_s1  <= valid_q[walk_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			wr_pos_q  <= '0;
			walk_q    <= '0;
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.walk_step;
			if (cmd.write) begin
				valid_q[wr_pos_q] <= 1'b1;
				if (wr_pos_q == ADDR_W'(WINDOW_DEPTH - 1)) begin
					wr_pos_q <= '0;
				end else begin
					wr_pos_q <= wr_pos_q + ADDR_W'(1);
				end
			end
			if (cmd.clear_acc) begin
				walk_q <= '0;
			end else if (cmd.walk_step) begin
				walk_q <= walk_last ? '0 : walk_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			total_q <= '0;
			min_q   <= ftws_pkg::SAMPLE_MAX;
			max_q   <= ftws_pkg::SAMPLE_MIN;
		end else if (acc_en_s1) begin
			total_q <= total_q + TOT_W'(entry);
			if (entry < min_q) begin
				min_q <= entry;
			end
			if (entry > max_q) begin
				max_q <= entry;
			end
		end
	end

	// The average divides the window's full-speed total; the other three divide one second.
	always_comb begin
		unique case (cmd.div_sel)
			ftws_pkg::SEL_AVG: begin
				div_dvd = TOT_W'(ftws_pkg::MS_PER_SEC * WINDOW_DEPTH);
				div_dsr = total_q;
			end
			ftws_pkg::SEL_BEST: begin
				div_dvd = TOT_W'(ftws_pkg::MS_PER_SEC);
				div_dsr = TOT_W'(min_q);
			end
			ftws_pkg::SEL_WORST: begin
				div_dvd = TOT_W'(ftws_pkg::MS_PER_SEC);
				div_dsr = TOT_W'(max_q);
			end
			ftws_pkg::SEL_INST: begin
				div_dvd = TOT_W'(ftws_pkg::MS_PER_SEC);
				div_dsr = TOT_W'(sample_q);
			end
			default: begin
				div_dvd = TOT_W'(ftws_pkg::MS_PER_SEC * WINDOW_DEPTH);
				div_dsr = total_q;
			end
		endcase
	end

	ftws_div #(
		.W(TOT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Every quotient is at most 1000, so the low bits carry it whole.
	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (cmd.div_sel)
				ftws_pkg::SEL_AVG:   avg_q   <= div_quot[FW-1:0];
				ftws_pkg::SEL_BEST:  best_q  <= div_quot[FW-1:0];
				ftws_pkg::SEL_WORST: worst_q <= div_quot[FW-1:0];
				ftws_pkg::SEL_INST:  inst_q  <= div_quot[FW-1:0];
				default:             avg_q   <= div_quot[FW-1:0];
			endcase
		end
	end

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			results.avg_fps       <= avg_q;
			results.best_excess   <= (best_q >= avg_q) ? best_q - avg_q : '0;
			results.worst_deficit <= (avg_q >= worst_q) ? avg_q - worst_q : '0;
			results.instant_fps   <= inst_q;
		end
	end

	assign results.valid = out_valid_q;

	always_comb begin
		sts.walk_last = walk_last;
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.out_free  = out_free;
	end

	`FTWS_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid_q || results.ready, "result overwritten")
	`FTWS_ASSERT_IMP(a_min_le_max, cmd.load_out, min_q <= max_q, "window minimum above maximum")
	`FTWS_ASSERT_IMP(a_total_floor, cmd.load_out, total_q >= TOT_W'(WINDOW_DEPTH), "window total too small")

endmodule

// File: hdl/ftws_ctrl.sv
// Controller state machine: sequences store, window walk, four divisions and result load.
// Depends on ftws_pkg and the assertion macro header.
`include "frame_time_window_stats_macros.svh"

module ftws_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ftws_pkg::ftws_sts_t sts,
	output ftws_pkg::ftws_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_WRITE    = 3'd1;
	localparam logic [2:0] S_WALK     = 3'd2;
	localparam logic [2:0] S_DRAIN    = 3'd3;
	localparam logic [2:0] S_DIV_GO   = 3'd4;
	localparam logic [2:0] S_DIV_WAIT = 3'd5;
	localparam logic [2:0] S_FINISH   = 3'd6;

	logic [2:0]                   state_q;
	logic [2:0]                   state_d;
	logic [ftws_pkg::SEL_W-1:0]   sel_q;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.capture   = in_ready && in_valid;
		cmd.write     = state_q == S_WRITE;
		cmd.clear_acc = state_q == S_WRITE;
		cmd.walk_step = state_q == S_WALK;
		cmd.div_start = state_q == S_DIV_GO;
		cmd.div_sel   = sel_q;
		cmd.load_out  = (state_q == S_FINISH) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_WRITE;
			S_WRITE:    state_d = S_WALK;
			S_WALK:     if (sts.walk_last) state_d = S_DRAIN;
			S_DRAIN:    state_d = S_DIV_GO;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = (sel_q == ftws_pkg::SEL_INST) ? S_FINISH : S_DIV_GO;
				end
			end
			S_FINISH:   if (sts.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= ftws_pkg::SEL_AVG;
		end else begin
			state_q <= state_d;
			if (state_q == S_DRAIN) begin
				sel_q <= ftws_pkg::SEL_AVG;
			end else if (state_q == S_DIV_WAIT && sts.div_done) begin
				sel_q <= sel_q + ftws_pkg::SEL_W'(1);
			end
		end
	end

	`FTWS_ASSERT_NXT(a_accept_to_write, cmd.capture, state_q == S_WRITE, "accept did not start a store")
	`FTWS_ASSERT_IMP(a_start_div_idle, cmd.div_start, !sts.div_busy && !sts.div_done, "divider restarted while busy")

endmodule

// File: dv/frame_time_window_stats_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_time_window_stats: directed and random frame times.
// Depends on ftws_pkg, ftws_in_if, ftws_out_if and the frame_time_window_stats RTL.
module frame_time_window_stats_tb;

	// The ring depth must match the instance below, which uses the package default.
	localparam int DEPTH = ftws_pkg::WINDOW_DEPTH_DEF;
	localparam int MS_PER_SEC = ftws_pkg::MS_PER_SEC;
	localparam int SAMPLE_CAP = 1000;

	// Wait well beyond the time a result takes once the last expected result is in.
	localparam int SETTLE_CYCLES = 300;

	// Watchdog limit, well above the slowest correct run: about 1300 items plus
	// sender gaps and receiver stalls.
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef logic [ftws_pkg::FPS_W-1:0] rate_t;

	// One result item, in the order of the output channel's fields.
	typedef struct packed {
		rate_t avg_fps;
		rate_t best_excess;
		rate_t worst_deficit;
		rate_t instant_fps;
	} frame_rates_t;

	logic clk;
	logic arst_n;

	ftws_in_if  samples_ch ();
	ftws_out_if results_ch ();

	frame_time_window_stats uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	// Predictor state: our own copy of the sample ring and its write position.
	logic [ftws_pkg::SAMPLE_W-1:0] window_ms [DEPTH];
	int unsigned                   window_wr;

	// Rates that the block still owes us, oldest first.
	frame_rates_t pending_rates [$];

	// Idle percentages for the sender and the receiver; changed between phases.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	int unsigned error_count;
	int unsigned result_count;
	int unsigned cycle_count;

	always #4 clk = ~clk;

	// Clear the predicted window the same way reset clears the block: every
	// entry reads as 1 ms and writing starts at the first entry.
	task automatic clear_window_model();
		for (int i = 0; i < DEPTH; i++) begin
			window_ms[i] = ftws_pkg::SAMPLE_W'(1);
		end
		window_wr = 0;
	endtask

	// Store one frame time in the predicted window and work out the rates the
	// block must report for it.
	function automatic frame_rates_t predict_rates(input logic [ftws_pkg::IN_W-1:0] ms);
		int unsigned  stored;
		int unsigned  total;
		int unsigned  shortest;
		int unsigned  longest;
		int unsigned  avg;
		int unsigned  best;
		int unsigned  worst;
		frame_rates_t rates;

		// A zero time is taken as 1 ms and anything longer than a second as 1000 ms.
		if (ms == '0) begin
			stored = 1;
		end else if (ms > SAMPLE_CAP) begin
			stored = SAMPLE_CAP;
		end else begin
			stored = ms;
		end

		window_ms[window_wr] = ftws_pkg::SAMPLE_W'(stored);
		window_wr = (window_wr == DEPTH - 1) ? 0 : window_wr + 1;

		total = 0;
		shortest = SAMPLE_CAP;
		longest = 1;
		for (int i = 0; i < DEPTH; i++) begin
			total += window_ms[i];
			if (window_ms[i] < shortest) begin
				shortest = window_ms[i];
			end
			if (window_ms[i] > longest) begin
				longest = window_ms[i];
			end
		end

		// The smallest entry gives the highest rate and the largest the lowest,
		// so the two differences below cannot go negative in practice.
		avg = (MS_PER_SEC * DEPTH) / total;
		best = MS_PER_SEC / shortest;
		worst = MS_PER_SEC / longest;

		rates.avg_fps = rate_t'(avg);
		rates.best_excess = rate_t'((best >= avg) ? best - avg : 0);
		rates.worst_deficit = rate_t'((avg >= worst) ? avg - worst : 0);
		rates.instant_fps = rate_t'(MS_PER_SEC / stored);
		return rates;
	endfunction

	// Every failed check goes through here: one line, one count.
	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input rate_t got, input rate_t want);
		if (got !== want) begin
			report_error($sformatf("result %0d, %s is %0d, expected %0d",
				result_count, name, got, want));
		end
	endtask

	// Offer one frame time and hold it until the block takes it. The valid
	// line is left high on return so that back-to-back items need no gap; the
	// next call replaces the item or lowers the line, or the end of the test lowers it.
	task automatic send_frame(input logic [ftws_pkg::IN_W-1:0] ms);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.frame_millis <= ms;
		do begin
			@(posedge clk);
		end while (!samples_ch.ready);
		// Accepted at this edge: the block now owes one result for it.
		pending_rates.push_back(predict_rates(ms));
	endtask

	// Receiver side. Values read here are those from just before the edge, so
	// a result counts as taken when valid and ready were both high then. Ready
	// is redrawn every cycle according to the current idle percentage.
	always @(posedge clk) begin : result_monitor
		frame_rates_t want;

		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_rates.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing outstanding",
					result_count));
			end else begin
				want = pending_rates.pop_front();
				check_field("avg_fps", results_ch.avg_fps, want.avg_fps);
				check_field("best_excess", results_ch.best_excess, want.best_excess);
				check_field("worst_deficit", results_ch.worst_deficit, want.worst_deficit);
				check_field("instant_fps", results_ch.instant_fps, want.instant_fps);
			end
			result_count++;
		end
		results_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Watchdog: a hang anywhere, including a result that never comes, ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Right after reset the ring holds 1 ms everywhere, so the first averages
	// start at 1000 and fall as longer samples come in.
	task automatic test_fresh_window();
		send_frame(16'd1);
		send_frame(16'd16);
		send_frame(16'd1000);
		send_frame(16'd33);
	endtask

	// Edges of the input range and of the clamp: zero, the top of the 16-bit
	// field, just either side of one second, and alternating bit patterns so
	// every input bit is seen at both levels early on.
	task automatic test_clamp_edges();
		send_frame(16'd0);
		send_frame(16'hFFFF);
		send_frame(16'd1001);
		send_frame(16'd1000);
		send_frame(16'd999);
		send_frame(16'd2);
		send_frame(16'h8000);
		send_frame(16'h5555);
		send_frame(16'h2AAA);
		send_frame(16'h03FF);
		send_frame(16'd3);
		send_frame(16'd7);
		send_frame(16'd333);
	endtask

	// Draw one frame time from the given band of values.
	function automatic logic [ftws_pkg::IN_W-1:0] draw_frame(input int unsigned band);
		logic [ftws_pkg::IN_W-1:0] ms;

		case (band)
			0: begin
				ms = ftws_pkg::IN_W'($urandom_range(0, 1));
			end
			1: begin
				ms = ftws_pkg::IN_W'($urandom_range(1, 20));
			end
			2: begin
				ms = ftws_pkg::IN_W'($urandom_range(10, 100));
			end
			3: begin
				ms = ftws_pkg::IN_W'($urandom_range(100, 1000));
			end
			4: begin
				ms = ftws_pkg::IN_W'($urandom_range(990, 1010));
			end
			5: begin
				ms = ftws_pkg::IN_W'($urandom_range(1001, 65535));
			end
			default: begin
				ms = ftws_pkg::IN_W'($urandom_range(0, 65535));
			end
		endcase
		return ms;
	endfunction

	// Random frame times in bursts. A burst mostly stays in one band of values
	// and is often longer than the window, so the ring fills with steady,
	// fast, slow or clamped frames before the next band mixes in; the rest of
	// the bursts pick a band per item.
	task automatic test_random_frames(input int unsigned count);
		int unsigned sent;
		int unsigned band;
		int unsigned burst;
		bit          mixed;

		sent = 0;
		while (sent < count) begin
			band = $urandom_range(0, 9);
			mixed = (band > 6);
			burst = $urandom_range(1, 2 * DEPTH);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_frame(draw_frame(mixed ? $urandom_range(0, 6) : band));
				sent++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.frame_millis = '0;
		results_ch.ready = 1'b0;
		error_count = 0;
		result_count = 0;
		cycle_count = 0;
		clear_window_model();

		// Sender sparse and receiver stalling hard for the directed part and
		// the first random stretch.
		send_idle_pct = 35;
		recv_idle_pct = 80;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fresh_window();
		test_clamp_edges();
		test_random_frames(430);

		// Now the sender is the slow side.
		send_idle_pct = 80;
		recv_idle_pct = 35;
		test_random_frames(430);

		// Full speed on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(430);

		samples_ch.valid <= 1'b0;
		while (pending_rates.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ftws_pkg.sv
hdl/ftws_in_if.sv
hdl/ftws_out_if.sv
hdl/ftws_div.sv
hdl/ftws_dp.sv
hdl/ftws_ctrl.sv
hdl/frame_time_window_stats.sv
dv/frame_time_window_stats_tb.sv
